// ===== hdl/plva_pkg.sv =====
// Package for the phase locking accumulator.
// Holds widths, opcodes and default sizes shared by all modules; no dependencies.
package plva_pkg;
	localparam int DEF_ENTRIES    = 4096;
	localparam int DEF_MAX_TRIALS = 1024;

	localparam int OPC_W  = 2;
	localparam int IDX_W  = 12;
	localparam int CSD_W  = 24;
	localparam int PLV_W  = 16;
	localparam int TC_W   = 11;
	localparam int SUM_W  = 27;
	localparam int WORD_W = 2 * SUM_W;
	localparam int PROD_W = 2 * SUM_W;

	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;
	localparam int NUM_W  = 48;
	localparam int DEN_W  = 32;

	localparam logic [OPC_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OPC_W-1:0] OP_ACC   = 2'd1;
	localparam logic [OPC_W-1:0] OP_READ  = 2'd2;

	typedef logic signed [SUM_W-1:0] sum_t;
endpackage

// ===== hdl/plva_mem.sv =====
// Phasor sum store: one synchronous memory of {sum_real, sum_imag} words.
// Clears itself after reset, one entry per cycle. Depends on plva_pkg.
module plva_mem
	import plva_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES,
	parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic              busy
);
	logic [WORD_W-1:0] mem [ENTRIES];
	logic [ADDR_W:0]   clr_cnt_q;
	logic              clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (ADDR_W+1)'(ENTRIES - 1))
				clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_cnt_q[ADDR_W-1:0]] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	assign busy = clr_q;
endmodule

// ===== hdl/plva_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
// Depends on plva_pkg.
module plva_sqrt
	import plva_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+2:0] rem_q;
	logic [4:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic              take;

	assign rem_sh = {rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'(ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== hdl/plva_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on plva_pkg.
module plva_div
	import plva_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [5:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             take;

	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-2:0], take};
			rem_q <= take ? rem_sh - {1'b0, den_q} : rem_sh;
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule

// ===== hdl/phase_locking_accumulator.sv =====
// Phase locking accumulator top level. Uses plva_pkg, plva_mem, plva_sqrt, plva_div.
// One item at a time; accumulate and read wait on the bit-serial square root and
// divider. A read result is registered before out_valid rises.
// After reset the store is swept to zero; no item is taken meanwhile.
module phase_locking_accumulator
	import plva_pkg::*;
#(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int MAX_TRIALS = DEF_MAX_TRIALS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [OPC_W-1:0]        opcode,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic signed [CSD_W-1:0] csd_real,
	input  logic signed [CSD_W-1:0] csd_imag,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [PLV_W-1:0]        plv_value,
	output logic [IDX_W-1:0]        read_entry,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [TC_W-1:0]         trial_count
);
	localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_AM1  = 4'd2;
	localparam logic [3:0] S_AM2  = 4'd3;
	localparam logic [3:0] S_ASQ  = 4'd4;
	localparam logic [3:0] S_ADR  = 4'd5;
	localparam logic [3:0] S_ADI  = 4'd6;
	localparam logic [3:0] S_RM1  = 4'd7;
	localparam logic [3:0] S_RM2  = 4'd8;
	localparam logic [3:0] S_RM3  = 4'd9;
	localparam logic [3:0] S_RSQ  = 4'd10;
	localparam logic [3:0] S_RDV  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0]              state_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    ok_q;
	logic signed [CSD_W-1:0] re_q;
	logic signed [CSD_W-1:0] im_q;
	logic [WORD_W-1:0]       word_q;
	logic [PROD_W:0]         p1_q;
	logic [ROOT_W-1:0]       g_q;
	logic [15:0]             qr_q;
	logic [PLV_W-1:0]        plv_q;
	logic [TC_W-1:0]         tc_q;
	logic                    out_valid_q;
	logic [PLV_W-1:0]        plv_out_q;
	logic [IDX_W-1:0]        ent_out_q;

	logic                    accept;
	logic                    in_ok;
	logic [ADDR_W-1:0]       addr;
	logic                    mem_busy;
	logic                    mem_rd;
	logic                    mem_wr;
	logic [WORD_W-1:0]       mem_wdata;
	logic [WORD_W-1:0]       mem_rdata;
	logic signed [SUM_W-1:0] mul_a;
	logic signed [SUM_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W:0]         psum;
	logic                    sq_start;
	logic [RAD_W-1:0]        sq_rad;
	logic                    sq_done;
	logic [ROOT_W-1:0]       sq_root;
	logic                    dv_start;
	logic [NUM_W-1:0]        dv_num;
	logic [DEN_W-1:0]        dv_den;
	logic                    dv_done;
	logic [NUM_W-1:0]        dv_quot;
	logic [15:0]             qclamp;
	logic [DEN_W-1:0]        n_eff;
	logic [CSD_W-1:0]        abs_re;
	logic [CSD_W-1:0]        abs_im;
	logic                    out_free;
	sum_t                    new_re;
	sum_t                    new_im;

	function automatic sum_t sat_add(sum_t s, logic neg, logic [15:0] q);
		logic signed [SUM_W:0] d;
		logic signed [SUM_W:0] r;
		d = neg ? -$signed({{(SUM_W-15){1'b0}}, q}) : $signed({{(SUM_W-15){1'b0}}, q});
		r = $signed({s[SUM_W-1], s}) + d;
		if (r > $signed({2'b00, {(SUM_W-1){1'b1}}}))
			return {1'b0, {(SUM_W-1){1'b1}}};
		else if (r < $signed({2'b11, {(SUM_W-1){1'b0}}}))
			return {1'b1, {(SUM_W-1){1'b0}}};
		else
			return r[SUM_W-1:0];
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || mem_busy;
	assign in_ok    = 32'(entry_index) < 32'(ENTRIES);
	assign addr     = ADDR_W'(idx_q);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign abs_re = re_q[CSD_W-1] ? CSD_W'(-re_q) : CSD_W'(re_q);
	assign abs_im = im_q[CSD_W-1] ? CSD_W'(-im_q) : CSD_W'(im_q);

	always_comb begin
		n_eff = DEN_W'(tc_q);
		if (tc_q == '0)
			n_eff = DEN_W'(1);
		else if (DEN_W'(tc_q) > DEN_W'(MAX_TRIALS))
			n_eff = DEN_W'(MAX_TRIALS);
	end

	always_comb begin
		case (state_q)
			S_AM1: begin
				mul_a = SUM_W'(re_q);
				mul_b = SUM_W'(re_q);
			end
			S_AM2: begin
				mul_a = SUM_W'(im_q);
				mul_b = SUM_W'(im_q);
			end
			S_RM2: begin
				mul_a = mem_rdata[WORD_W-1 -: SUM_W];
				mul_b = mem_rdata[WORD_W-1 -: SUM_W];
			end
			S_RM3: begin
				mul_a = word_q[SUM_W-1:0];
				mul_b = word_q[SUM_W-1:0];
			end
			default: begin
				mul_a = SUM_W'(re_q);
				mul_b = SUM_W'(im_q);
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign psum = p1_q + {1'b0, prod};

	assign qclamp = (dv_quot > NUM_W'(32767)) ? 16'd32767 : dv_quot[15:0];
	assign new_re = sat_add(word_q[WORD_W-1 -: SUM_W], re_q[CSD_W-1], qr_q);
	assign new_im = sat_add(word_q[SUM_W-1:0], im_q[CSD_W-1], qclamp);

	always_comb begin
		sq_start = 1'b0;
		sq_rad   = '0;
		dv_start = 1'b0;
		dv_num   = '0;
		dv_den   = '0;
		mem_rd   = 1'b0;
		mem_wr   = 1'b0;
		mem_wdata = '0;
		case (state_q)
			S_CLR: begin
				mem_wr = ok_q;
			end
			S_AM1, S_RM1: begin
				mem_rd = 1'b1;
			end
			S_AM2: begin
				sq_start = ok_q && (psum != '0);
				sq_rad   = {psum[NUM_W-1:0], 16'd0};
			end
			S_RM3: begin
				sq_start = 1'b1;
				sq_rad   = RAD_W'({psum, 2'b00});
			end
			S_ASQ: begin
				dv_start = sq_done;
				dv_num   = (NUM_W'(abs_re) << 23) + NUM_W'(sq_root >> 1);
				dv_den   = sq_root;
			end
			S_ADR: begin
				dv_start = dv_done;
				dv_num   = (NUM_W'(abs_im) << 23) + NUM_W'(g_q >> 1);
				dv_den   = g_q;
			end
			S_ADI: begin
				mem_wr    = dv_done;
				mem_wdata = {new_re, new_im};
			end
			S_RSQ: begin
				dv_start = sq_done;
				dv_num   = NUM_W'(sq_root);
				dv_den   = n_eff;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tc_q        <= TC_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				tc_q <= trial_count;
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_CLEAR: state_q <= S_CLR;
							OP_ACC:   state_q <= S_AM1;
							OP_READ:  state_q <= in_ok ? S_RM1 : S_OUT;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_CLR:  state_q <= S_IDLE;
				S_AM1:  state_q <= S_AM2;
				S_AM2:  state_q <= sq_start ? S_ASQ : S_IDLE;
				S_ASQ:  if (sq_done) state_q <= S_ADR;
				S_ADR:  if (dv_done) state_q <= S_ADI;
				S_ADI:  if (dv_done) state_q <= S_IDLE;
				S_RM1:  state_q <= S_RM2;
				S_RM2:  state_q <= S_RM3;
				S_RM3:  state_q <= S_RSQ;
				S_RSQ:  if (sq_done) state_q <= S_RDV;
				S_RDV:  if (dv_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= entry_index;
			ok_q  <= in_ok;
			re_q  <= csd_real;
			im_q  <= csd_imag;
			plv_q <= '0;
		end
		if (state_q == S_AM1 || state_q == S_RM2)
			p1_q <= {1'b0, prod};
		if (state_q == S_AM2 || state_q == S_RM2)
			word_q <= mem_rdata;
		if (state_q == S_ASQ && sq_done)
			g_q <= sq_root;
		if (state_q == S_ADR && dv_done)
			qr_q <= qclamp;
		if (state_q == S_RDV && dv_done)
			plv_q <= (dv_quot > NUM_W'(65535)) ? 16'hFFFF : dv_quot[PLV_W-1:0];
		if (state_q == S_OUT && out_free) begin
			plv_out_q <= plv_q;
			ent_out_q <= idx_q;
		end
	end

	plva_mem #(
		.ENTRIES(ENTRIES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (mem_rd),
		.rd_addr(addr),
		.rd_data(mem_rdata),
		.wr_en  (mem_wr),
		.wr_addr(addr),
		.wr_data(mem_wdata),
		.busy   (mem_busy)
	);

	plva_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(sq_rad),
		.done    (sq_done),
		.root    (sq_root)
	);

	plva_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dv_start),
		.num   (dv_num),
		.den   (dv_den),
		.done  (dv_done),
		.quot  (dv_quot)
	);

	assign out_valid  = out_valid_q;
	assign plv_value  = plv_out_q;
	assign read_entry = ent_out_q;

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> in_stall)
		else $error("item taken during store clear");
	a_sqrt_owner: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == S_ASQ || state_q == S_RSQ))
		else $error("square root finished outside its state");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (state_q == S_ADR || state_q == S_ADI || state_q == S_RDV))
		else $error("divide finished outside its state");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && out_stall) |=> state_q == S_OUT)
		else $error("result dropped while output busy");
	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr |=> state_q == S_IDLE)
		else $error("write not followed by idle");
endmodule
